/* rtl/core/timestamp_ordered_frame_buffer_assert.svh */
// assertion macros for the timestamp ordered frame buffer
`ifndef TIMESTAMP_ORDERED_FRAME_BUFFER_ASSERT_SVH
`define TIMESTAMP_ORDERED_FRAME_BUFFER_ASSERT_SVH

`ifndef ASSERT_OFF
// checked while out of reset
`define TOFB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define TOFB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TOFB_ASSERT(lbl, clk, rst_n, prop, msg)
`define TOFB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/core/tofb_pkg.sv */
// shared types and constants of the timestamp ordered frame buffer
package tofb_pkg;

    localparam int DEPTH        = 32;
    localparam int TIME_BITS    = 40;
    localparam int TAG_BITS     = 16;
    localparam int TOL_BITS     = 24;
    localparam int CAP_BITS     = 6;
    localparam int STAT_BITS    = 32;
    localparam int CMD_BITS     = 4;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DW       = 24;
    localparam int AW           = $clog2(DEPTH);
    localparam int CW           = $clog2(DEPTH + 1);

    localparam logic [CMD_BITS-1:0] CMD_PUSH       = 4'd0;
    localparam logic [CMD_BITS-1:0] CMD_FETCH      = 4'd1;
    localparam logic [CMD_BITS-1:0] CMD_PEEK       = 4'd2;
    localparam logic [CMD_BITS-1:0] CMD_DROP_OLDER = 4'd3;
    localparam logic [CMD_BITS-1:0] CMD_KEEP_LAST  = 4'd4;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR      = 4'd5;
    localparam logic [CMD_BITS-1:0] CMD_HAS        = 4'd6;
    localparam logic [CMD_BITS-1:0] CMD_COUNT      = 4'd7;
    localparam logic [CMD_BITS-1:0] CMD_CLR_STATS  = 4'd8;

    localparam logic [CFG_IDX_BITS-1:0] REG_CAPACITY  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DROP_EN   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOLERANCE = 2'd2;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 6'd32;
    localparam logic [TOL_BITS-1:0] TOL_RESET = 24'd16667;

    typedef struct packed {
        logic [CAP_BITS-1:0] cap;
        logic                drop_en;
        logic [TOL_BITS-1:0] tol;
    } t_cfg;

    typedef struct packed {
        logic [TIME_BITS-1:0] ts;
        logic [TAG_BITS-1:0]  tag;
    } t_mem_word;

    typedef struct packed {
        logic            we;
        logic [AW-1:0]   waddr;
        t_mem_word       wdata;
        logic            re;
        logic [AW-1:0]   raddr;
    } t_ram_req;

    function automatic logic [STAT_BITS-1:0] sat_add(input logic [STAT_BITS-1:0] a,
                                                     input logic [CW-1:0] n);
        logic [STAT_BITS:0] s;
        s = {1'b0, a} + {{(STAT_BITS+1-CW){1'b0}}, n};
        return s[STAT_BITS] ? {STAT_BITS{1'b1}} : s[STAT_BITS-1:0];
    endfunction

endpackage

/* rtl/core/tofb_in_if.sv */
// command channel of the frame buffer
interface tofb_in_if;
    import tofb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_BITS-1:0]  command;
    logic [TIME_BITS-1:0] time_value;
    logic [TIME_BITS-1:0] range_end;
    logic [TAG_BITS-1:0]  frame_tag;

    modport source (output valid, command, time_value, range_end, frame_tag, input ready);
    modport sink   (input valid, command, time_value, range_end, frame_tag, output ready);
endinterface

/* rtl/core/tofb_out_if.sv */
// result channel of the frame buffer
interface tofb_out_if;
    import tofb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  success;
    logic [TAG_BITS-1:0]   tag_out;
    logic [TIME_BITS-1:0]  time_out;
    logic [CW-1:0]         count_out;
    logic [CW-1:0]         occupancy;
    logic [TIME_BITS-1:0]  earliest_time;
    logic [TIME_BITS-1:0]  latest_time;
    logic [STAT_BITS-1:0]  dropped_total;
    logic [STAT_BITS-1:0]  overrun_total;

    modport source (output valid, success, tag_out, time_out, count_out, occupancy,
                    earliest_time, latest_time, dropped_total, overrun_total,
                    input ready);
    modport sink   (input valid, success, tag_out, time_out, count_out, occupancy,
                    earliest_time, latest_time, dropped_total, overrun_total,
                    output ready);
endinterface

/* rtl/core/timestamp_ordered_frame_buffer.sv */
// top level of the timestamp ordered frame buffer
//
//  channel  | dir | handshake         | payload
//  i_cmd    | in  | valid/ready       | command, time_value, range_end, frame_tag
//  o_res    | out | valid/ready       | success .. overrun_total, one beat per command
//  i_cfg_*  | in  | write enable only | capacity_limit, drop_enable, match_tolerance
//
// one command at a time; entries sit in a ring in a single 1r1w ram
// scan commands (fetch, drop older, has, count) read every entry once through the
// single ram read port, one entry per cycle; push reads down from the tail over the
// entries later than the new stamp, moving each up by one
// reset is synchronous and needs no clearing pass; a stalled result beat holds the
// next command in its last state until the beat is taken
module timestamp_ordered_frame_buffer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tofb_in_if.sink                           i_cmd,
    tofb_out_if.source                        o_res,
    input  logic                              i_cfg_we,
    input  logic [tofb_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [tofb_pkg::CFG_DW-1:0]       i_cfg_data
);
    import tofb_pkg::*;

    t_cfg                         cfg;
    t_ram_req                     ram_req;
    t_mem_word                    ram_rdata;
    logic [$bits(t_mem_word)-1:0] ram_rdata_raw;

    tofb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    tofb_ram #(
        .AW (AW),
        .DW ($bits(t_mem_word))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata_raw)
    );

    assign ram_rdata = ram_rdata_raw;

    tofb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_cmd   (i_cmd),
        .o_res   (o_res),
        .o_ram   (ram_req),
        .i_rdata (ram_rdata)
    );
endmodule

/* rtl/core/tofb_ram.sv */
// simple dual port ram, one write and one registered read port
module tofb_ram #(
    parameter int AW = 5,
    parameter int DW = 56
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/tofb_cfg.sv */
// configuration registers of the frame buffer
module tofb_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_we,
    input  logic [tofb_pkg::CFG_IDX_BITS-1:0] i_idx,
    input  logic [tofb_pkg::CFG_DW-1:0]       i_data,
    output tofb_pkg::t_cfg                    o_cfg
);
    import tofb_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cap     <= CAP_RESET;
            r_cfg.drop_en <= 1'b1;
            r_cfg.tol     <= TOL_RESET;
        end else if (i_we) begin
            case (i_idx)
                REG_CAPACITY:  r_cfg.cap     <= i_data[CAP_BITS-1:0];
                REG_DROP_EN:   r_cfg.drop_en <= i_data[0];
                REG_TOLERANCE: r_cfg.tol     <= i_data[TOL_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

/* rtl/core/tofb_ctrl.sv */
// command sequencer: scans, inserts and trims the ring held in the entry ram
module tofb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tofb_pkg::t_cfg      i_cfg,
    tofb_in_if.sink             i_cmd,
    tofb_out_if.source          o_res,
    output tofb_pkg::t_ram_req  o_ram,
    input  tofb_pkg::t_mem_word i_rdata
);
    import tofb_pkg::*;
    `include "timestamp_ordered_frame_buffer_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_SCAN, S_INS, S_PUT, S_FIN_A, S_FIN_B, S_FIN_C
    } t_state;

    t_state                r_state;
    logic                  r_out_pend;
    logic [CMD_BITS-1:0]   r_cmd;
    logic [TIME_BITS-1:0]  r_t;
    logic [TIME_BITS-1:0]  r_tend;
    logic [TAG_BITS-1:0]   r_tag;
    logic [AW-1:0]         r_head;
    logic [CW-1:0]         r_count;
    logic [STAT_BITS-1:0]  r_drops;
    logic [STAT_BITS-1:0]  r_overs;
    logic [CW-1:0]         r_ri;
    logic [CW-1:0]         r_vi;
    logic                  r_rv;
    logic                  r_found;
    logic [CW-1:0]         r_best;
    logic [TIME_BITS-1:0]  r_best_d;
    logic                  r_succ;
    logic [TAG_BITS-1:0]   r_tag_o;
    logic [TIME_BITS-1:0]  r_time_o;
    logic [CW-1:0]         r_cnt;
    logic [TIME_BITS-1:0]  r_early;

    logic [CW-1:0]         cap_eff;
    logic [CW+1:0]         cap3;
    logic [CW-1:0]         target;
    logic                  full;
    logic [CW-1:0]         n_drop;
    logic [CW-1:0]         n_count;
    logic [TIME_BITS-1:0]  ts_gap;
    logic                  in_tol;
    logic                  rd_later;
    logic                  issue;
    logic                  ins_shift;
    logic                  ins_place;
    logic [CW-1:0]         place_idx;
    logic [CW-1:0]         tail_idx;
    logic [CW-1:0]         n_take;
    t_ram_req              ram;

    always_comb begin
        cap_eff  = (i_cfg.cap > CAP_BITS'(DEPTH)) ? CW'(DEPTH) : CW'(i_cfg.cap);
        cap3     = {2'b00, cap_eff} + {1'b0, cap_eff, 1'b0};
        target   = cap3[CW+1:2];
        full     = (r_count >= cap_eff);
        n_drop   = (r_count > target) ? r_count - target : '0;
        n_count  = r_count - n_drop;
        rd_later = (i_rdata.ts > r_t);
        ts_gap   = rd_later ? i_rdata.ts - r_t : r_t - i_rdata.ts;
        in_tol   = (ts_gap <= {{(TIME_BITS-TOL_BITS){1'b0}}, i_cfg.tol});
        n_take   = r_best + CW'(1);
        tail_idx = r_count - CW'(1);
    end

    // insertion walks down from the tail, moving later entries up by one
    always_comb begin
        ins_shift = 1'b0;
        ins_place = 1'b0;
        place_idx = '0;
        issue     = 1'b0;
        ram       = '0;
        case (r_state)
            S_INS: begin
                ins_shift = r_rv && rd_later;
                ins_place = (r_rv && !rd_later) || (!r_rv && r_ri == '0);
                place_idx = r_rv ? r_vi + CW'(1) : '0;
                issue     = (r_ri != '0);
                ram.re    = issue;
                ram.raddr = r_head + r_ri[AW-1:0] - AW'(1);
                ram.we    = ins_shift || ins_place;
                ram.waddr = r_head + place_idx[AW-1:0];
                ram.wdata = ins_shift ? i_rdata : t_mem_word'{ts: r_t, tag: r_tag};
            end
            S_PUT: begin
                ram.we    = 1'b1;
                ram.waddr = r_head;
                ram.wdata = t_mem_word'{ts: r_t, tag: r_tag};
            end
            S_SCAN: begin
                issue     = (r_ri < r_count);
                ram.re    = issue;
                ram.raddr = r_head + r_ri[AW-1:0];
            end
            S_FIN_A: begin
                ram.re    = 1'b1;
                ram.raddr = r_head;
            end
            S_FIN_B: begin
                ram.re    = 1'b1;
                ram.raddr = r_head + tail_idx[AW-1:0];
            end
            default: ;
        endcase
    end

    assign o_ram       = ram;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_res.valid = r_out_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_pend <= 1'b0;
            r_head     <= '0;
            r_count    <= '0;
            r_drops    <= '0;
            r_overs    <= '0;
            r_rv       <= 1'b0;
        end else begin
            // a new beat loaded in S_FIN_C keeps the flag set
            if (o_res.valid && o_res.ready && r_state != S_FIN_C) begin
                r_out_pend <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd   <= i_cmd.command;
                        r_t     <= i_cmd.time_value;
                        r_tend  <= i_cmd.range_end;
                        r_tag   <= i_cmd.frame_tag;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_succ   <= 1'b0;
                    r_tag_o  <= '0;
                    r_time_o <= '0;
                    r_found  <= 1'b0;
                    r_best   <= '0;
                    r_best_d <= '0;
                    r_rv     <= 1'b0;
                    case (r_cmd)
                        CMD_PUSH: begin
                            if (full && !i_cfg.drop_en) begin
                                r_overs <= sat_add(r_overs, CW'(1));
                                r_cnt   <= '0;
                                r_ri    <= '0;
                                r_state <= S_FIN_A;
                            end else if (full) begin
                                r_cnt   <= n_drop;
                                r_head  <= r_head + n_drop[AW-1:0];
                                r_count <= n_count;
                                r_drops <= sat_add(r_drops, n_drop);
                                r_ri    <= n_count;
                                r_state <= S_INS;
                            end else begin
                                r_cnt   <= '0;
                                r_ri    <= r_count;
                                r_state <= S_INS;
                            end
                        end
                        CMD_FETCH, CMD_DROP_OLDER, CMD_HAS, CMD_COUNT: begin
                            r_cnt   <= '0;
                            r_ri    <= '0;
                            r_state <= S_SCAN;
                        end
                        CMD_KEEP_LAST: begin
                            r_ri    <= '0;
                            r_state <= S_FIN_A;
                            if (r_count != '0) begin
                                r_cnt   <= tail_idx;
                                r_head  <= r_head + tail_idx[AW-1:0];
                                r_count <= CW'(1);
                                r_drops <= sat_add(r_drops, tail_idx);
                            end else begin
                                r_cnt   <= '0;
                            end
                        end
                        CMD_CLEAR: begin
                            r_count <= '0;
                            r_cnt   <= '0;
                            r_ri    <= '0;
                            r_state <= S_FIN_A;
                        end
                        CMD_CLR_STATS: begin
                            r_drops <= '0;
                            r_overs <= '0;
                            r_cnt   <= '0;
                            r_ri    <= '0;
                            r_state <= S_FIN_A;
                        end
                        default: begin
                            r_cnt   <= '0;
                            r_ri    <= '0;
                            r_state <= S_FIN_A;
                        end
                    endcase
                end
                S_INS: begin
                    r_rv <= issue;
                    if (issue) begin
                        r_ri <= r_ri - CW'(1);
                        r_vi <= r_ri - CW'(1);
                    end
                    if (ins_place) begin
                        r_count <= r_count + CW'(1);
                        r_succ  <= 1'b1;
                        r_state <= S_FIN_A;
                    end else if (ins_shift && r_vi == '0) begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    r_rv    <= 1'b0;
                    r_count <= r_count + CW'(1);
                    r_succ  <= 1'b1;
                    r_state <= S_FIN_A;
                end
                S_SCAN: begin
                    r_rv <= issue;
                    if (issue) begin
                        r_ri <= r_ri + CW'(1);
                        r_vi <= r_ri;
                    end
                    if (r_rv) begin
                        case (r_cmd)
                            CMD_FETCH: begin
                                // equal distances tie, so the first one wins
                                if (in_tol && (!r_found || ts_gap < r_best_d)) begin
                                    r_found  <= 1'b1;
                                    r_best   <= r_vi;
                                    r_best_d <= ts_gap;
                                    r_time_o <= i_rdata.ts;
                                    r_tag_o  <= i_rdata.tag;
                                end
                            end
                            CMD_DROP_OLDER: begin
                                if (i_rdata.ts < r_t) begin
                                    r_cnt <= r_cnt + CW'(1);
                                end
                            end
                            CMD_HAS: begin
                                if (in_tol) begin
                                    r_succ <= 1'b1;
                                end
                            end
                            CMD_COUNT: begin
                                if (i_rdata.ts >= r_t && i_rdata.ts <= r_tend) begin
                                    r_cnt <= r_cnt + CW'(1);
                                end
                            end
                            default: ;
                        endcase
                    end else if (r_ri == r_count) begin
                        r_state <= S_FIN_A;
                        if (r_cmd == CMD_FETCH && r_found) begin
                            // the match and everything ahead of it leave together
                            r_succ  <= 1'b1;
                            r_cnt   <= r_best;
                            r_head  <= r_head + n_take[AW-1:0];
                            r_count <= r_count - n_take;
                            r_drops <= sat_add(r_drops, r_best);
                        end else if (r_cmd == CMD_DROP_OLDER) begin
                            r_head  <= r_head + r_cnt[AW-1:0];
                            r_count <= r_count - r_cnt;
                            r_drops <= sat_add(r_drops, r_cnt);
                        end
                    end
                end
                S_FIN_A: begin
                    r_rv    <= 1'b0;
                    r_state <= S_FIN_B;
                end
                S_FIN_B: begin
                    r_early <= i_rdata.ts;
                    if (r_cmd == CMD_PEEK && r_count != '0) begin
                        r_succ   <= 1'b1;
                        r_time_o <= i_rdata.ts;
                        r_tag_o  <= i_rdata.tag;
                    end
                    r_state <= S_FIN_C;
                end
                S_FIN_C: begin
                    if (!r_out_pend || o_res.ready) begin
                        r_out_pend <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result beat payload, loaded as the sequence completes
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN_C && (!r_out_pend || o_res.ready)) begin
            o_res.success       <= r_succ;
            o_res.tag_out       <= r_tag_o;
            o_res.time_out      <= r_time_o;
            o_res.count_out     <= r_cnt;
            o_res.occupancy     <= r_count;
            o_res.earliest_time <= (r_count != '0) ? r_early : '0;
            o_res.latest_time   <= (r_count != '0) ? i_rdata.ts : '0;
            o_res.dropped_total <= r_drops;
            o_res.overrun_total <= r_overs;
        end
    end

    `TOFB_ASSERT(a_no_rw_clash, i_clk, i_rst_n, !(ram.we && ram.re && ram.waddr == ram.raddr), "ram read and write hit one entry")
    `TOFB_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "entry count above depth")
    `TOFB_ASSERT(a_accept_starts, i_clk, i_rst_n, (i_cmd.valid && i_cmd.ready) |=> (r_state == S_PREP), "accepted beat did not start a command")
    `TOFB_ASSERT_ALWAYS(a_write_in_ins, i_clk, ram.we |-> (r_state == S_INS || r_state == S_PUT), "ram written outside insertion")
endmodule

/* tb/sv/tofb_tb_pkg.sv */
// testbench types used by the checker
package tofb_tb_pkg;
    import tofb_pkg::*;

    typedef struct packed {
        logic                 success;
        logic [TAG_BITS-1:0]  tag_out;
        logic [TIME_BITS-1:0] time_out;
        logic [CW-1:0]        count_out;
        logic [CW-1:0]        occupancy;
        logic [TIME_BITS-1:0] earliest_time;
        logic [TIME_BITS-1:0] latest_time;
        logic [STAT_BITS-1:0] dropped_total;
        logic [STAT_BITS-1:0] overrun_total;
    } t_result;
endpackage

/* tb/sv/tofb_tb_checker.sv */
// checker: predicts every result beat of the frame buffer and compares
module tofb_tb_checker
    import tofb_pkg::*;
    import tofb_tb_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    tofb_in_if                      i_cmd,
    tofb_out_if                     o_res,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0]       i_cfg_data,
    output int                      o_errors,
    output int                      o_pending,
    output int                      o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [TIME_BITS-1:0] buf_time[DEPTH];
    logic [TAG_BITS-1:0]  buf_tag[DEPTH];
    int                   fill;
    logic [STAT_BITS-1:0] drops, overruns;
    logic [CAP_BITS-1:0]  cap_reg;
    logic                 drop_en_reg;
    logic [TOL_BITS-1:0]  tol_reg;
    t_result              expected_q[$];

    initial begin
        o_errors = 0;
        o_results = 0;
    end
    assign o_pending = expected_q.size();

    function automatic logic [STAT_BITS-1:0] add_sat(logic [STAT_BITS-1:0] a, int n);
        logic [STAT_BITS:0] s;
        s = {1'b0, a} + n;
        return s[STAT_BITS] ? '1 : s[STAT_BITS-1:0];
    endfunction

    function automatic void shift_out(int n);
        if (n > fill) n = fill;
        for (int k = 0; k + n < fill; k++) begin
            buf_time[k] = buf_time[k+n];
            buf_tag[k]  = buf_tag[k+n];
        end
        fill -= n;
    endfunction

    function automatic void remove_entry(int idx);
        for (int k = idx; k < fill - 1; k++) begin
            buf_time[k] = buf_time[k+1];
            buf_tag[k]  = buf_tag[k+1];
        end
        fill--;
    endfunction

    function automatic int discard_before(logic [TIME_BITS-1:0] t);
        int n;
        n = 0;
        while (n < fill && buf_time[n] < t) n++;
        shift_out(n);
        drops = add_sat(drops, n);
        return n;
    endfunction

    function automatic logic [TIME_BITS:0] gap(logic [TIME_BITS-1:0] a, logic [TIME_BITS-1:0] b);
        return a > b ? a - b : b - a;
    endfunction

    function automatic t_result apply_command(logic [CMD_BITS-1:0] cmd, logic [TIME_BITS-1:0] t,
                                              logic [TIME_BITS-1:0] t_end,
                                              logic [TAG_BITS-1:0] tag);
        t_result r;
        int cap, cnt, pos, best;
        logic found;
        logic [TIME_BITS:0] best_d, d;
        r = '0;
        cnt = 0;
        cap = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
        case (cmd)
            CMD_PUSH: begin
                found = 1'b1;
                if (fill >= cap) begin
                    if (drop_en_reg) begin
                        cnt = (fill > cap * 3 / 4) ? fill - cap * 3 / 4 : 0;
                        shift_out(cnt);
                        drops = add_sat(drops, cnt);
                    end else begin
                        overruns = add_sat(overruns, 1);
                        found = 1'b0;
                    end
                end
                if (found && fill < DEPTH) begin
                    pos = 0;
                    while (pos < fill && buf_time[pos] <= t) pos++;
                    for (int k = fill; k > pos; k--) begin
                        buf_time[k] = buf_time[k-1];
                        buf_tag[k]  = buf_tag[k-1];
                    end
                    buf_time[pos] = t;
                    buf_tag[pos]  = tag;
                    fill++;
                    r.success = 1'b1;
                end
            end
            CMD_FETCH: begin
                found = 1'b0;
                best = 0;
                best_d = '0;
                for (int k = 0; k < fill; k++) begin
                    d = gap(buf_time[k], t);
                    if (d <= tol_reg && (!found || d < best_d)) begin
                        found = 1'b1;
                        best = k;
                        best_d = d;
                    end
                end
                if (found) begin
                    r.time_out = buf_time[best];
                    r.tag_out  = buf_tag[best];
                    remove_entry(best);
                    cnt = discard_before(r.time_out);
                    r.success = 1'b1;
                end
            end
            CMD_PEEK: if (fill > 0) begin
                r.time_out = buf_time[0];
                r.tag_out  = buf_tag[0];
                r.success  = 1'b1;
            end
            CMD_DROP_OLDER: cnt = discard_before(t);
            CMD_KEEP_LAST: if (fill > 0) begin
                cnt = fill - 1;
                shift_out(cnt);
                drops = add_sat(drops, cnt);
            end
            CMD_CLEAR: fill = 0;
            CMD_HAS: for (int k = 0; k < fill; k++)
                if (gap(buf_time[k], t) <= tol_reg) r.success = 1'b1;
            CMD_COUNT: for (int k = 0; k < fill; k++)
                if (buf_time[k] >= t && buf_time[k] <= t_end) cnt++;
            CMD_CLR_STATS: begin
                drops = '0;
                overruns = '0;
            end
            default: ;
        endcase
        r.count_out = CW'(cnt);
        r.occupancy = CW'(fill);
        if (fill > 0) begin
            r.earliest_time = buf_time[0];
            r.latest_time   = buf_time[fill-1];
        end
        r.dropped_total = drops;
        r.overrun_total = overruns;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            fill <= 0;
            drops <= '0;
            overruns <= '0;
            cap_reg <= CAP_RESET;
            drop_en_reg <= 1'b1;
            tol_reg <= TOL_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CAPACITY:  cap_reg <= i_cfg_data[CAP_BITS-1:0];
                    REG_DROP_EN:   drop_en_reg <= i_cfg_data[0];
                    REG_TOLERANCE: tol_reg <= i_cfg_data[TOL_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.valid && i_cmd.ready)
                expected_q.insert(expected_q.size(),
                                  apply_command(i_cmd.command, i_cmd.time_value,
                                                i_cmd.range_end, i_cmd.frame_tag));
            if (o_res.valid && o_res.ready) begin
                got = '{o_res.success, o_res.tag_out, o_res.time_out, o_res.count_out,
                        o_res.occupancy, o_res.earliest_time, o_res.latest_time,
                        o_res.dropped_total, o_res.overrun_total};
                o_results++;
                if (expected_q.size() == 0) begin
                    report_mismatch("result beat with nothing expected", '0, '0);
                end else begin
                    want = expected_q[0];
                    expected_q.delete(0);
                    if (got.success != want.success)
                        report_mismatch("success", got.success, want.success);
                    if (got.tag_out != want.tag_out)
                        report_mismatch("tag_out", got.tag_out, want.tag_out);
                    if (got.time_out != want.time_out)
                        report_mismatch("time_out", got.time_out, want.time_out);
                    if (got.count_out != want.count_out)
                        report_mismatch("count_out", got.count_out, want.count_out);
                    if (got.occupancy != want.occupancy)
                        report_mismatch("occupancy", got.occupancy, want.occupancy);
                    if (got.earliest_time != want.earliest_time)
                        report_mismatch("earliest_time", got.earliest_time, want.earliest_time);
                    if (got.latest_time != want.latest_time)
                        report_mismatch("latest_time", got.latest_time, want.latest_time);
                    if (got.dropped_total != want.dropped_total)
                        report_mismatch("dropped_total", got.dropped_total, want.dropped_total);
                    if (got.overrun_total != want.overrun_total)
                        report_mismatch("overrun_total", got.overrun_total, want.overrun_total);
                end
            end
        end
    end
endmodule

/* tb/sv/tb_top.sv */
// stimulus top of the frame buffer testbench
module tb_top;
    import tofb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [CFG_DW-1:0]       i_cfg_data = '0;
    int                      errors, pending, results;
    int                      send_idle_pct = 0, stall_pct = 0, hold_cycles = 0;
    int                      hold_requests = 0, hold_served = 0;
    int                      sent = 0;
    logic [TIME_BITS-1:0]    base_time = 40'd1_000_000;

    tofb_in_if  cmd_ch();
    tofb_out_if res_ch();

    timestamp_ordered_frame_buffer uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd_ch.sink), .o_res(res_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    tofb_tb_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd_ch), .o_res(res_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off counted here
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_cycles <= 400;
            res_ch.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // valid stays up after an accepted beat until the next beat, a gap or a drain
    task automatic send_beat(logic [CMD_BITS-1:0] cmd, logic [TIME_BITS-1:0] t,
                             logic [TIME_BITS-1:0] t_end, logic [TAG_BITS-1:0] tag);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.time_value <= t;
        cmd_ch.range_end <= t_end;
        cmd_ch.frame_tag <= tag;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sent++;
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DW-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // near timestamps cluster around a moving base so fetches and matches hit
    function automatic logic [TIME_BITS-1:0] near_time();
        case ($urandom_range(9))
            0: return TIME_BITS'({$urandom, $urandom});
            1: return base_time;
            default: return base_time + $urandom_range(60000) - 20000;
        endcase
    endfunction

    task automatic random_beat();
        logic [CMD_BITS-1:0] cmd;
        logic [TIME_BITS-1:0] t;
        int r;
        r = $urandom_range(99);
        if (r < 45) cmd = CMD_PUSH;
        else if (r < 60) cmd = CMD_FETCH;
        else if (r < 97) cmd = CMD_BITS'($urandom_range(2, 8));
        else cmd = CMD_BITS'($urandom_range(9, 15));
        if (cmd == CMD_PUSH || cmd == CMD_FETCH) base_time += $urandom_range(17000);
        t = near_time();
        send_beat(cmd, t, ($urandom_range(3) == 0) ? near_time() : t + $urandom_range(50000),
                  TAG_BITS'($urandom));
    endtask

    task automatic random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        stall_pct = stall;
        repeat (n) random_beat();
        drain();
    endtask

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.command = '0;
        cmd_ch.time_value = '0;
        cmd_ch.range_end = '0;
        cmd_ch.frame_tag = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, each command, corner cases
        send_beat(CMD_PEEK, '0, '0, '0);
        send_beat(CMD_FETCH, '0, '0, '0);
        send_beat(CMD_PUSH, '0, '0, '0);
        send_beat(CMD_PUSH, '1, '0, '1);
        send_beat(CMD_PUSH, 40'd100, '0, 16'h1234);
        send_beat(CMD_PUSH, 40'd100, '0, 16'h5678);
        send_beat(CMD_COUNT, 40'd100, '1, '0);
        send_beat(CMD_COUNT, '1, '0, '0);
        send_beat(CMD_HAS, 40'd16767, '0, '0);
        send_beat(CMD_HAS, 40'd16768, '0, '0);
        send_beat(CMD_PEEK, '0, '0, '0);
        send_beat(CMD_FETCH, 40'd50, '0, '0);
        send_beat(CMD_DROP_OLDER, 40'd101, '0, '0);
        send_beat(CMD_KEEP_LAST, '0, '0, '0);
        send_beat(CMD_PUSH, 40'h55_5555_5555, '0, 16'haaaa);
        send_beat(CMD_CLEAR, '0, '0, '0);
        send_beat(CMD_KEEP_LAST, '0, '0, '0);
        send_beat(CMD_CLR_STATS, '0, '0, '0);
        send_beat(4'd9, '1, '1, '1);
        send_beat(4'd15, '0, '0, '0);
        drain();

        // capacity zero with dropping, then refusing; tolerance extremes
        write_reg(REG_CAPACITY, CFG_DW'(0));
        write_reg(REG_TOLERANCE, '1);
        repeat (3) send_beat(CMD_PUSH, 40'd5, '0, 16'h1);
        send_beat(CMD_FETCH, '1, '0, '0);
        drain();
        write_reg(REG_DROP_EN, CFG_DW'(0));
        write_reg(REG_TOLERANCE, CFG_DW'(0));
        repeat (2) send_beat(CMD_PUSH, 40'd7, '0, 16'h2);
        drain();

        random_phase(150, 0, 0);
        write_reg(REG_CAPACITY, CFG_DW'(63));
        write_reg(REG_DROP_EN, CFG_DW'(1));
        write_reg(REG_TOLERANCE, 24'd16667);
        random_phase(300, 0, 0);
        // long hold-off while commands keep coming
        hold_requests++;
        random_phase(60, 0, 0);
        write_reg(REG_CAPACITY, CFG_DW'(4));
        random_phase(300, 87, 0);
        write_reg(REG_CAPACITY, CFG_DW'(1));
        write_reg(REG_TOLERANCE, 24'd3000);
        random_phase(250, 0, 87);
        write_reg(REG_CAPACITY, CFG_DW'(32));
        write_reg(REG_DROP_EN, CFG_DW'(0));
        write_reg(REG_TOLERANCE, 24'd500000);
        random_phase(300, 16, 16);
        write_reg(REG_CAPACITY, CFG_DW'(12));
        write_reg(REG_DROP_EN, CFG_DW'(1));
        random_phase(300, 0, 0);
        // lower capacity below occupancy without a trim
        write_reg(REG_CAPACITY, CFG_DW'(2));
        random_phase(150, 16, 16);

        $display("covered %0d commands and %0d result beats across capacity, drop and",
                 sent, results);
        $display("tolerance settings with sender gaps, receiver stalls and a long hold-off");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #4ms;
        $display("timeout: %0d results still expected", pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/tofb_pkg.sv
rtl/core/tofb_in_if.sv
rtl/core/tofb_out_if.sv
rtl/core/tofb_ram.sv
rtl/core/tofb_cfg.sv
rtl/core/tofb_ctrl.sv
rtl/core/timestamp_ordered_frame_buffer.sv
tb/sv/tofb_tb_pkg.sv
tb/sv/tofb_tb_checker.sv
tb/sv/tb_top.sv
